/* sv/cdl_pkg.sv */
// Shared types and constants of the class-data LEB128 decoder.
package cdl_pkg;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_STATIC   = 3'd1,
    PH_INSTANCE = 3'd2,
    PH_DIRECT   = 3'd3,
    PH_VIRTUAL  = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam int unsigned NUM_SECTIONS = 4;
  localparam int unsigned LEB_MAX_BYTES = 5;
  localparam int unsigned RESULT_PAD = 5;

  typedef struct packed {
    logic [31:0] extra_count;
    logic [31:0] code_offset;
    logic [31:0] flags_value;
    logic [31:0] index_value;
    logic [31:0] element_index;
    logic [2:0]  record_kind;
  } result_t;

  typedef struct packed {
    logic       done;
    logic [31:0] value;
  } leb_status_t;

endpackage

/* sv/cdl_leb_acc.sv */
// LEB128 byte accumulator: gathers up to five bytes into one 32-bit value.
module cdl_leb_acc (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               clear,
  input  logic [7:0]         data_byte,
  output cdl_pkg::leb_status_t status
);

  localparam logic [2:0] LastPos = 3'(cdl_pkg::LEB_MAX_BYTES - 1);

  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [2:0]  pos;
  logic [2:0]  pos_next;
  logic [31:0] acc_eff;
  logic [2:0]  pos_eff;
  logic [31:0] merged;
  logic        done;

  always_comb begin
    acc_eff = clear ? 32'd0 : acc;
    pos_eff = clear ? 3'd0 : pos;
    done    = 1'b1;
    case (pos_eff)
      3'd0: merged = acc_eff | {25'd0, data_byte[6:0]};
      3'd1: merged = acc_eff | {18'd0, data_byte[6:0], 7'd0};
      3'd2: merged = acc_eff | {11'd0, data_byte[6:0], 14'd0};
      3'd3: merged = acc_eff | {4'd0, data_byte[6:0], 21'd0};
      default: merged = acc_eff | {data_byte[3:0], 28'd0};
    endcase
    if (pos_eff < LastPos) begin
      done = ~data_byte[7];
    end
    acc_next = acc;
    pos_next = pos;
    if (en) begin
      if (done) begin
        acc_next = 32'd0;
        pos_next = 3'd0;
      end else begin
        acc_next = merged;
        pos_next = pos_eff + 3'd1;
      end
    end
    status.done  = done;
    status.value = merged;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 32'd0;
      pos <= 3'd0;
    end else begin
      acc <= acc_next;
      pos <= pos_next;
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= LastPos)
    else $error("byte position beyond the fifth byte");
`endif

endmodule

/* sv/class_data_leb128_decoder.sv */
// Top level of the class-data LEB128 decoder with its stream ports.
// One byte is taken per transfer on the slave side and a new byte can be taken in every
// cycle; the decode of a byte is done in the cycle it is taken and a finished header or
// record appears in the output register on the next cycle, so throughput is one byte per
// clock, limited only by the single output register (the slave side stalls only while a
// result waits and the master side is not ready). tuser high on a byte restarts the item
// at its header. Each result carries the record kind, its position in its section and up
// to four decoded values; tlast marks the record that completes the item.
module class_data_leb128_decoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // start_of_item
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata,   // record_kind, element_index, index_value, flags_value,
                                  // code_offset, extra_count, zero padding
  output logic         m_tlast    // last_record
);

  function automatic cdl_pkg::phase_t next_section(input logic [2:0] first,
                                                   input logic [3:0] nonzero);
    cdl_pkg::phase_t result;
    result = cdl_pkg::PH_DONE;
    for (int s = cdl_pkg::NUM_SECTIONS; s >= 1; s--) begin
      if ((3'(s) >= first) && nonzero[s-1]) begin
        result = cdl_pkg::phase_t'(3'(s));
      end
    end
    return result;
  endfunction

  cdl_pkg::phase_t phase;
  cdl_pkg::phase_t phase_next;
  cdl_pkg::phase_t phase_eff;
  logic [1:0]  slot;
  logic [1:0]  slot_next;
  logic [1:0]  slot_eff;
  logic [31:0] counts [cdl_pkg::NUM_SECTIONS];
  logic [31:0] counts_next [cdl_pkg::NUM_SECTIONS];
  logic [31:0] counts_eff [cdl_pkg::NUM_SECTIONS];
  logic [31:0] counter;
  logic [31:0] counter_next;
  logic [31:0] counter_eff;
  logic [31:0] held [2];
  logic [31:0] held_next [2];
  logic [31:0] held_eff [2];
  logic [3:0]  nonzero;
  logic [1:0]  sect_idx;
  logic [31:0] counter_inc;

  logic        accept;
  logic        active;
  logic        emit;
  logic        emit_last;
  cdl_pkg::result_t res;
  cdl_pkg::leb_status_t leb;

  cdl_pkg::result_t res_reg;
  logic        last_reg;
  logic        out_valid;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !out_valid || m_tready;

  always_comb begin
    phase_eff   = s_tuser ? cdl_pkg::PH_HEADER : phase;
    slot_eff    = s_tuser ? 2'd0 : slot;
    counter_eff = s_tuser ? 32'd0 : counter;
    for (int i = 0; i < cdl_pkg::NUM_SECTIONS; i++) begin
      counts_eff[i] = s_tuser ? 32'd0 : counts[i];
    end
    for (int i = 0; i < 2; i++) begin
      held_eff[i] = s_tuser ? 32'd0 : held[i];
    end
    active = phase_eff <= cdl_pkg::PH_VIRTUAL;
  end

  cdl_leb_acc u_leb (
    .clk       (clk),
    .rst       (rst),
    .en        (accept && active),
    .clear     (accept && s_tuser),
    .data_byte (s_tdata),
    .status    (leb)
  );

  always_comb begin
    phase_next   = phase;
    slot_next    = slot;
    counter_next = counter;
    counts_next  = counts;
    held_next    = held;
    emit         = 1'b0;
    emit_last    = 1'b0;
    res          = '0;
    nonzero      = 4'd0;
    sect_idx     = 2'(phase_eff - 3'd1);
    counter_inc  = counter_eff + 32'd1;
    if (accept) begin
      phase_next   = phase_eff;
      slot_next    = slot_eff;
      counter_next = counter_eff;
      counts_next  = counts_eff;
      held_next    = held_eff;
      if (active && leb.done) begin
        if (phase_eff == cdl_pkg::PH_HEADER) begin
          counts_next[slot_eff] = leb.value;
          if (slot_eff != 2'd3) begin
            slot_next = slot_eff + 2'd1;
          end else begin
            for (int i = 0; i < cdl_pkg::NUM_SECTIONS; i++) begin
              nonzero[i] = counts_next[i] != 32'd0;
            end
            phase_next        = next_section(3'd1, nonzero);
            slot_next         = 2'd0;
            counter_next      = 32'd0;
            emit              = 1'b1;
            emit_last         = phase_next == cdl_pkg::PH_DONE;
            res.record_kind   = cdl_pkg::KIND_HEADER;
            res.element_index = 32'd0;
            res.index_value   = counts_next[0];
            res.flags_value   = counts_next[1];
            res.code_offset   = counts_next[2];
            res.extra_count   = counts_next[3];
          end
        end else if (slot_eff == 2'd0) begin
          held_next[0] = leb.value;
          slot_next    = 2'd1;
        end else if ((phase_eff >= cdl_pkg::PH_DIRECT) && (slot_eff == 2'd1)) begin
          held_next[1] = leb.value;
          slot_next    = 2'd2;
        end else begin
          emit              = 1'b1;
          res.record_kind   = phase_eff;
          res.element_index = counter_eff;
          res.index_value   = held_eff[0];
          if (phase_eff >= cdl_pkg::PH_DIRECT) begin
            res.flags_value = held_eff[1];
            res.code_offset = leb.value;
          end else begin
            res.flags_value = leb.value;
          end
          slot_next    = 2'd0;
          counter_next = counter_inc;
          if (counter_inc == counts_eff[sect_idx]) begin
            for (int i = 0; i < cdl_pkg::NUM_SECTIONS; i++) begin
              nonzero[i] = counts_eff[i] != 32'd0;
            end
            phase_next   = next_section(phase_eff + 3'd1, nonzero);
            counter_next = 32'd0;
            emit_last    = phase_next == cdl_pkg::PH_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= cdl_pkg::PH_HEADER;
      slot    <= 2'd0;
      counter <= 32'd0;
      for (int i = 0; i < cdl_pkg::NUM_SECTIONS; i++) begin
        counts[i] <= 32'd0;
      end
      held[0] <= 32'd0;
      held[1] <= 32'd0;
    end else begin
      phase   <= phase_next;
      slot    <= slot_next;
      counter <= counter_next;
      counts  <= counts_next;
      held    <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_reg  <= res;
      last_reg <= emit_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{cdl_pkg::RESULT_PAD{1'b0}}, res_reg};
  assign m_tlast  = last_reg;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while a result is held");
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (res_reg.record_kind <= 3'(cdl_pkg::PH_VIRTUAL)))
    else $error("record kind out of range");
  a_done_slot: assert property (@(posedge clk) disable iff (rst)
      (phase == cdl_pkg::PH_DONE) |-> ((slot == 2'd0) && (counter == 32'd0)))
    else $error("completed item with a record in progress");
  a_counter_below: assert property (@(posedge clk) disable iff (rst)
      ((phase != cdl_pkg::PH_HEADER) && (phase != cdl_pkg::PH_DONE))
        |-> (counter < counts[2'(phase - 3'd1)]))
    else $error("element counter reached its section count");
  a_emit_on_accept: assert property (@(posedge clk) disable iff (rst)
      emit |-> accept)
    else $error("result produced without an input transfer");
`endif

endmodule

/* tb/class_data_leb128_checker.sv */
// Checker that predicts the class-data LEB128 decoder's records and compares them on the fly.
module class_data_leb128_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [167:0] m_tdata,
  input  logic         m_tlast,
  output int           fail_count,
  output int           pending,
  output int           records_seen,
  output int           items_done
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cdl_pkg::result_t rec;
    logic             last;
  } record_exp_t;

  record_exp_t expected_records[$];

  logic [31:0]     acc;
  logic [2:0]      byte_pos;
  cdl_pkg::phase_t phase;
  logic [1:0]      slot;
  logic [31:0]     counts [cdl_pkg::NUM_SECTIONS];
  logic [31:0]     elem_count;
  logic [31:0]     held_index;
  logic [31:0]     held_flags;
  int              mismatches = 0;
  int              seen = 0;
  int              completed = 0;

  function automatic void clear_state();
    acc        = '0;
    byte_pos   = '0;
    phase      = cdl_pkg::PH_HEADER;
    slot       = '0;
    elem_count = '0;
    held_index = '0;
    held_flags = '0;
    for (int i = 0; i < cdl_pkg::NUM_SECTIONS; i++) counts[i] = '0;
  endfunction

  // Returns 1 when no non-empty section is left, which completes the item.
  function automatic logic enter_section_from(input int first);
    elem_count = '0;
    slot       = '0;
    for (int s = first; s <= cdl_pkg::NUM_SECTIONS; s++) begin
      if (counts[s - 1] != 0) begin
        phase = cdl_pkg::phase_t'(s);
        return 1'b0;
      end
    end
    phase = cdl_pkg::PH_DONE;
    return 1'b1;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic sof);
    logic [31:0] v;
    logic [2:0]  kind;
    record_exp_t e;
    if (sof) clear_state();
    if (phase > cdl_pkg::PH_VIRTUAL) return;
    if (byte_pos < 3'(cdl_pkg::LEB_MAX_BYTES - 1)) begin
      acc = acc | (32'(b[6:0]) << (7 * byte_pos));
      if (b[7]) begin
        byte_pos = byte_pos + 3'd1;
        return;
      end
    end else begin
      acc = acc | {b[3:0], 28'd0};
    end
    v        = acc;
    acc      = '0;
    byte_pos = '0;
    e.rec    = '0;
    if (phase == cdl_pkg::PH_HEADER) begin
      counts[slot] = v;
      if (slot < 2'd3) begin
        slot = slot + 2'd1;
        return;
      end
      e.rec.record_kind = cdl_pkg::KIND_HEADER;
      e.rec.index_value = counts[0];
      e.rec.flags_value = counts[1];
      e.rec.code_offset = counts[2];
      e.rec.extra_count = counts[3];
      e.last = enter_section_from(1);
      expected_records.push_back(e);
      return;
    end
    kind = phase;
    if (slot == 2'd0) begin
      held_index = v;
      slot = 2'd1;
      return;
    end
    if (kind >= cdl_pkg::PH_DIRECT && slot == 2'd1) begin
      held_flags = v;
      slot = 2'd2;
      return;
    end
    e.rec.record_kind   = kind;
    e.rec.element_index = elem_count;
    e.rec.index_value   = held_index;
    if (kind <= cdl_pkg::PH_INSTANCE) begin
      e.rec.flags_value = v;
    end else begin
      e.rec.flags_value = held_flags;
      e.rec.code_offset = v;
    end
    e.last     = 1'b0;
    slot       = '0;
    elem_count = elem_count + 32'd1;
    if (elem_count == counts[kind - 3'd1]) e.last = enter_section_from(kind + 1);
    expected_records.push_back(e);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 20)
      $display("Mismatch on record %0d: %s is %h, expected %h", seen, what, got, want);
  endtask

  task automatic check_record();
    cdl_pkg::result_t got;
    record_exp_t      e;
    got = m_tdata[162:0];
    seen++;
    if (m_tlast) completed++;
    if (expected_records.size() == 0) begin
      report_mismatch("record kind of a transfer with nothing expected",
                      32'(got.record_kind), 32'd0);
      return;
    end
    e = expected_records.pop_front();
    if (got.record_kind != e.rec.record_kind)
      report_mismatch("record_kind", 32'(got.record_kind), 32'(e.rec.record_kind));
    if (got.element_index != e.rec.element_index)
      report_mismatch("element_index", got.element_index, e.rec.element_index);
    if (got.index_value != e.rec.index_value)
      report_mismatch("index_value", got.index_value, e.rec.index_value);
    if (got.flags_value != e.rec.flags_value)
      report_mismatch("flags_value", got.flags_value, e.rec.flags_value);
    if (got.code_offset != e.rec.code_offset)
      report_mismatch("code_offset", got.code_offset, e.rec.code_offset);
    if (got.extra_count != e.rec.extra_count)
      report_mismatch("extra_count", got.extra_count, e.rec.extra_count);
    if (m_tdata[167:163] !== '0)
      report_mismatch("padding", 32'(m_tdata[167:163]), 32'd0);
    if (m_tlast !== e.last)
      report_mismatch("last_record", 32'(m_tlast), 32'(e.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_records.delete();
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) check_record();
    end
    pending      <= expected_records.size();
    fail_count   <= mismatches;
    records_seen <= seen;
    items_done   <= completed;
  end

endmodule

/* tb/class_data_leb128_decoder_tb.sv */
// Testbench top of the class-data LEB128 decoder: clock, reset, byte stimulus and verdict.
module class_data_leb128_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_BYTES  = 1150;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_mode_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'd0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;
  logic         m_tlast;

  int fail_count;
  int pending;
  int records_seen;
  int items_done;

  int       cycle_count = 0;
  int       stall_timer = 0;
  rx_mode_t stall_mode = RX_ALWAYS;
  int       burst_left = 0;
  int       bytes_sent = 0;
  logic [7:0] item_q[$];

  class_data_leb128_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  class_data_leb128_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .records_seen (records_seen),
    .items_done   (items_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d records outstanding.", cycle_count, pending);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  <= rx_mode_t'($urandom_range(0, 3));
      stall_timer <= $urandom_range(50, 400);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      RX_ALWAYS: m_tready <= 1'b1;
      RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
      RX_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= ((cycle_count % 5) != 0);
    endcase
  end

  function automatic int uleb_min_len(input logic [31:0] v);
    if (v < 32'h80) return 1;
    if (v < 32'h4000) return 2;
    if (v < 32'h20_0000) return 3;
    if (v < 32'h1000_0000) return 4;
    return 5;
  endfunction

  // A five-byte value carries random junk in the upper half of its closing byte.
  task automatic push_uleb_len(input logic [31:0] v, input int len);
    for (int i = 0; i < len; i++) begin
      if (i == cdl_pkg::LEB_MAX_BYTES - 1)
        item_q.push_back({4'($urandom_range(0, 15)), v[31:28]});
      else
        item_q.push_back(((i < len - 1) ? 8'h80 : 8'h00) | {1'b0, 7'(v >> (7 * i))});
    end
  endtask

  task automatic push_uleb(input logic [31:0] v);
    int len;
    len = uleb_min_len(v);
    if ($urandom_range(0, 3) == 0) len = $urandom_range(len, cdl_pkg::LEB_MAX_BYTES);
    push_uleb_len(v, len);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 127);
      3:       return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_random_item(input int unsigned cnt [4]);
    for (int s = 0; s < 4; s++) push_uleb(cnt[s]);
    for (int s = 0; s < 4; s++) begin
      for (int n = 0; n < cnt[s]; n++) begin
        push_uleb(rand_value());
        push_uleb(rand_value());
        if (s >= 2) push_uleb(rand_value());
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic sof);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= sof;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  task automatic send_item(input logic sof, input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(item_q[i], sof && (i == 0));
      bytes_sent++;
    end
    item_q.delete();
  endtask

  initial begin
    int          pick;
    int unsigned cnt [4];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // After reset the first item needs no start mark.
    push_uleb_len(1, 1);
    push_uleb_len(1, 5);
    push_uleb_len(1, 1);
    push_uleb_len(1, 1);
    push_uleb_len(0, 1);
    push_uleb_len(32'hFFFF_FFFF, 5);
    push_uleb_len(32'h7F, 1);
    push_uleb_len(0, 2);
    push_uleb_len(32'h80, 2);
    push_uleb_len(32'h0FFF_FFFF, 4);
    push_uleb_len(32'h1000_0000, 5);
    push_uleb_len(32'hFFFF_FFFF, 5);
    push_uleb_len(5, 3);
    push_uleb_len(32'h3FFF, 2);
    send_item(1'b0, item_q.size());
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);

    for (int i = 0; i < 4; i++) push_uleb_len(0, 1);
    send_item(1'b1, item_q.size());

    // A huge static count, cut short in the middle of the second record.
    push_uleb_len(32'hFFFF_FFFF, 5);
    for (int i = 0; i < 3; i++) push_uleb_len(0, 1);
    push_uleb_len(3, 1);
    push_uleb_len(4, 1);
    push_uleb_len(6, 1);
    item_q.push_back(8'h85);
    send_item(1'b1, item_q.size());

    push_uleb_len(0, 1);
    push_uleb_len(1, 1);
    push_uleb_len(0, 1);
    push_uleb_len(1, 1);
    push_uleb_len(2, 1);
    push_uleb_len(32'h3FFF, 2);
    push_uleb_len(9, 1);
    push_uleb_len(8, 1);
    push_uleb_len(7, 1);
    send_item(1'b1, item_q.size());

    while (bytes_sent < ITEM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        for (int s = 0; s < 4; s++)
          cnt[s] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
        if ($urandom_range(0, 11) == 0) cnt = '{0, 0, 0, 0};
        push_random_item(cnt);
        send_item(1'b1, (pick < 76) ? item_q.size() : $urandom_range(1, item_q.size()));
        if (pick < 76 && $urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_byte(8'($urandom), $urandom_range(0, 3) == 0);
          bytes_sent++;
        end
      end
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes of well-formed, truncated and noisy class data with idling on both",
             bytes_sent);
    $display("sides; checked %0d records, %0d of them closing an item.", records_seen, items_done);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
